>>> sv/kti_pkg.sv
// Shared types, codes and constants of the keyframe table interpolator.
package kti_pkg;

  localparam int MAX_KEYFRAMES_DEF  = 32;
  localparam int NUM_PROPERTIES_DEF = 64;

  localparam int KEY_W  = 17;
  localparam int PROP_W = 6;
  localparam int VAL_W  = 24;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 33;
  localparam int PROD_W = 58;
  localparam int DIV_W  = 60;

  localparam logic [DUR_W-1:0] DURATION_RESET = 16'd256;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_STRIP  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SET_SCAN,
    ST_SET_ACT,
    ST_SET_WR,
    ST_REM_SCAN,
    ST_STRIP_SCAN,
    ST_Q_RD,
    ST_Q_UPD,
    ST_Q_MUL,
    ST_Q_DIVI,
    ST_Q_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic inc;
    logic ins;
    logic del;
    logic wr_val;
    logic set_full;
    logic q_rd;
    logic q_upd;
    logic mul;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic prop_ok;
    logic in_range;
    logic pos_lt;
    logic pos_eq;
    logic full;
    logic pres_zero;
    logic interp;
    logic div_last;
  } sts_t;

endpackage

>>> sv/kti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kti_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/kti_datapath.sv
// Keyframe table storage, scan compare, interpolation multiply and divider.
module kti_datapath #(
  parameter int MAX_KEYFRAMES  = kti_pkg::MAX_KEYFRAMES_DEF,
  parameter int NUM_PROPERTIES = kti_pkg::NUM_PROPERTIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kti_pkg::cmd_t                 cmd_i,
  output kti_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [kti_pkg::DUR_W-1:0]     cfg_wdata_i,
  input  logic [1:0]                    req_type_i,
  input  logic [kti_pkg::KEY_W-1:0]     key_point_i,
  input  logic [kti_pkg::PROP_W-1:0]    property_index_i,
  input  logic [kti_pkg::VAL_W-1:0]     new_value_i,
  input  logic [kti_pkg::KEY_W-1:0]     query_point_i,
  input  logic                          at_is_timestamp_i,
  output logic [kti_pkg::VAL_W-1:0]     result_value_o,
  output logic                          found_o,
  output logic                          status_o
);
  import kti_pkg::*;

  localparam int IW   = $clog2(MAX_KEYFRAMES);
  localparam int CW   = $clog2(MAX_KEYFRAMES + 1);
  localparam int PW   = (NUM_PROPERTIES > 1) ? $clog2(NUM_PROPERTIES) : 1;
  localparam int AW   = IW + PW;
  localparam int DCW  = $clog2(DIV_W + 1);

  req_e                   req_q;
  logic [KEY_W-1:0]       key_q;
  logic [PROP_W-1:0]      prop_q;
  logic [VAL_W-1:0]       val_q;
  logic [TIME_W-1:0]      at_q;
  logic                   ts_q;
  logic [DUR_W-1:0]       dur_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          idx_q;
  logic [KEY_W-1:0]       pos_q   [MAX_KEYFRAMES];
  logic [NUM_PROPERTIES-1:0] pres_q [MAX_KEYFRAMES];
  logic [IW-1:0]          order_q [MAX_KEYFRAMES];
  logic [TIME_W-1:0]      t_q;
  logic                   hit_q;
  logic                   hp_q, hn_q;
  logic [TIME_W-1:0]      tp_q, tn_q;
  logic [VAL_W-1:0]       vp_q, vn_q;
  logic signed [PROD_W-1:0] p_q;
  logic [DIV_W-1:0]       a_q;
  logic [TIME_W:0]        rem_q;
  logic [TIME_W-1:0]      dd_q;
  logic                   neg_q;
  logic [DCW-1:0]         dcnt_q;
  logic                   status_q;
  logic [VAL_W-1:0]       res_q;
  logic                   has_q;
  logic                   stat_q;

  logic [IW-1:0]          iw;
  logic [PW-1:0]          pbit;
  logic [AW-1:0]          ram_addr;
  logic [VAL_W-1:0]       ram_rdata;
  logic [CW-1:0]          cm1;
  logic                   prop_ok;
  logic [TIME_W-1:0]      t_mul;
  logic [TIME_W-1:0]      delta;
  logic [TIME_W-1:0]      dspan;
  logic signed [VAL_W:0]  diff;
  logic signed [PROD_W-1:0] prod;
  logic [DIV_W-1:0]       n_val;
  logic [DIV_W-1:0]       dd_ext;
  logic [DIV_W-1:0]       a_init;
  logic [TIME_W:0]        remsh;
  logic                   q_ge;
  logic [DIV_W-1:0]       qv;
  logic [VAL_W-1:0]       value;
  logic                   t_le, t_ge;

  assign iw       = idx_q[IW-1:0];
  assign pbit     = prop_q[PW-1:0];
  assign ram_addr = {order_q[iw], pbit};
  assign cm1      = count_q - 1'b1;
  assign prop_ok  = {1'b0, prop_q} < (PROP_W+1)'(NUM_PROPERTIES);

  assign t_mul = ts_q ? (TIME_W'(pos_q[iw]) * TIME_W'(dur_q)) : TIME_W'(pos_q[iw]);
  assign t_le  = t_q <= at_q;
  assign t_ge  = t_q >= at_q;

  assign delta = at_q - tp_q;
  assign dspan = tn_q - tp_q;
  assign diff  = $signed({vn_q[VAL_W-1], vn_q}) - $signed({vp_q[VAL_W-1], vp_q});
  assign prod  = PROD_W'(diff) * PROD_W'($signed({1'b0, delta[31:0]}));

  // round half up: floor((2p + d) / 2d), signed numerator
  assign n_val  = {{(DIV_W-PROD_W-1){p_q[PROD_W-1]}}, p_q, 1'b0} + DIV_W'(dspan[31:0]);
  assign dd_ext = DIV_W'({dspan[31:0], 1'b0});
  assign a_init = n_val[DIV_W-1] ? ((~n_val + 1'b1) + dd_ext - 1'b1) : n_val;

  assign remsh = {rem_q[TIME_W-1:0], a_q[DIV_W-1]};
  assign q_ge  = remsh >= {1'b0, dd_q};
  assign qv    = neg_q ? (~a_q + 1'b1) : a_q;

  always_comb begin
    if (hp_q && hn_q) begin
      value = (tp_q == tn_q) ? vp_q : (vp_q + qv[VAL_W-1:0]);
    end else if (hp_q) begin
      value = vp_q;
    end else if (hn_q) begin
      value = vn_q;
    end else begin
      value = '0;
    end
  end

  kti_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_KEYFRAMES << PW)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_val),
    .waddr_i(ram_addr),
    .wdata_i(val_q),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q    <= DURATION_RESET;
      count_q  <= '0;
      idx_q    <= '0;
      hp_q     <= 1'b0;
      hn_q     <= 1'b0;
      status_q <= 1'b0;
      dcnt_q   <= '0;
      for (int k = 0; k < MAX_KEYFRAMES; k++) begin
        pres_q[k]  <= '0;
        order_q[k] <= IW'(k);
      end
    end else begin
      if (cfg_we_i) begin
        dur_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q    <= '0;
        hp_q     <= 1'b0;
        hn_q     <= 1'b0;
        status_q <= 1'b0;
      end
      if (cmd_i.inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_full) begin
        status_q <= 1'b1;
      end
      if (cmd_i.ins) begin
        // open a gap at idx, reuse the first free slot id
        for (int k = 1; k < MAX_KEYFRAMES; k++) begin
          if (CW'(k) > idx_q && CW'(k) <= count_q) begin
            pres_q[k]  <= pres_q[k-1];
            order_q[k] <= order_q[k-1];
          end
        end
        pres_q[iw]  <= '0;
        order_q[iw] <= order_q[count_q[IW-1:0]];
        count_q     <= count_q + 1'b1;
      end
      if (cmd_i.del) begin
        // close the gap, park the freed slot id past the end
        for (int k = 0; k < MAX_KEYFRAMES - 1; k++) begin
          if (CW'(k) >= idx_q && CW'(k + 1) < count_q) begin
            pres_q[k]  <= pres_q[k+1];
            order_q[k] <= order_q[k+1];
          end
        end
        order_q[cm1[IW-1:0]] <= order_q[iw];
        count_q              <= cm1;
      end
      if (cmd_i.wr_val) begin
        pres_q[iw][pbit] <= 1'b1;
      end
      if (cmd_i.q_upd && hit_q) begin
        if (t_le && (!hp_q || tp_q < t_q)) begin
          hp_q <= 1'b1;
        end
        if (t_ge && (!hn_q || tn_q > t_q)) begin
          hn_q <= 1'b1;
        end
      end
      if (cmd_i.div_init) begin
        dcnt_q <= DCW'(DIV_W);
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_e'(req_type_i);
      key_q  <= key_point_i;
      prop_q <= property_index_i;
      val_q  <= new_value_i;
      ts_q   <= at_is_timestamp_i;
      at_q   <= at_is_timestamp_i ? {query_point_i, 16'd0} : TIME_W'(query_point_i);
    end
    if (cmd_i.ins) begin
      for (int k = 1; k < MAX_KEYFRAMES; k++) begin
        if (CW'(k) > idx_q && CW'(k) <= count_q) begin
          pos_q[k] <= pos_q[k-1];
        end
      end
      pos_q[iw] <= key_q;
    end
    if (cmd_i.del) begin
      for (int k = 0; k < MAX_KEYFRAMES - 1; k++) begin
        if (CW'(k) >= idx_q && CW'(k + 1) < count_q) begin
          pos_q[k] <= pos_q[k+1];
        end
      end
    end
    if (cmd_i.q_rd) begin
      t_q   <= t_mul;
      hit_q <= pres_q[iw][pbit];
    end
    if (cmd_i.q_upd && hit_q) begin
      if (t_le && (!hp_q || tp_q < t_q)) begin
        tp_q <= t_q;
        vp_q <= ram_rdata;
      end
      if (t_ge && (!hn_q || tn_q > t_q)) begin
        tn_q <= t_q;
        vn_q <= ram_rdata;
      end
    end
    if (cmd_i.mul) begin
      p_q <= prod;
    end
    if (cmd_i.div_init) begin
      a_q   <= a_init;
      rem_q <= '0;
      dd_q  <= TIME_W'({dspan[31:0], 1'b0});
      neg_q <= n_val[DIV_W-1];
    end
    if (cmd_i.div_step) begin
      rem_q <= q_ge ? (remsh - {1'b0, dd_q}) : remsh;
      a_q   <= {a_q[DIV_W-2:0], q_ge};
    end
    if (cmd_i.emit) begin
      res_q  <= (req_q == REQ_QUERY) ? value : '0;
      has_q  <= (req_q == REQ_QUERY) && (hp_q || hn_q);
      stat_q <= status_q;
    end
  end

  assign sts_o.req       = req_q;
  assign sts_o.prop_ok   = prop_ok;
  assign sts_o.in_range  = idx_q < count_q;
  assign sts_o.pos_lt    = pos_q[iw] < key_q;
  assign sts_o.pos_eq    = pos_q[iw] == key_q;
  assign sts_o.full      = count_q == CW'(MAX_KEYFRAMES);
  assign sts_o.pres_zero = pres_q[iw] == '0;
  assign sts_o.interp    = hp_q && hn_q && (tp_q != tn_q);
  assign sts_o.div_last  = dcnt_q == DCW'(1);

  assign result_value_o = res_q;
  assign found_o        = has_q;
  assign status_o       = stat_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYFRAMES)) else $error("keyframe count above table size");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |-> (count_q < CW'(MAX_KEYFRAMES))) else $error("insert into full table");
  a_del_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.del |-> (idx_q < count_q)) else $error("remove past table end");
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |=> (count_q == $past(count_q) + 1'b1)) else $error("insert lost count");
`endif

endmodule

>>> sv/kti_ctrl.sv
// Request sequencer: dispatches each transaction and steps the datapath.
module kti_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  kti_pkg::sts_t sts_i,
  output kti_pkg::cmd_t cmd_o
);
  import kti_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.req)
          REQ_SET:    state_d = sts_i.prop_ok ? ST_SET_SCAN : ST_FINISH;
          REQ_REMOVE: state_d = ST_REM_SCAN;
          REQ_QUERY:  state_d = sts_i.prop_ok ? ST_Q_RD : ST_FINISH;
          REQ_STRIP:  state_d = ST_STRIP_SCAN;
          default:    state_d = ST_FINISH;
        endcase
      end
      ST_SET_SCAN: begin
        if (sts_i.in_range && sts_i.pos_lt) begin
          cmd_o.inc = 1'b1;
        end else begin
          state_d = ST_SET_ACT;
        end
      end
      ST_SET_ACT: begin
        priority if (sts_i.in_range && sts_i.pos_eq) begin
          cmd_o.wr_val = 1'b1;
          state_d      = ST_FINISH;
        end else if (sts_i.full) begin
          cmd_o.set_full = 1'b1;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.ins = 1'b1;
          state_d   = ST_SET_WR;
        end
      end
      ST_SET_WR: begin
        cmd_o.wr_val = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_REM_SCAN: begin
        priority if (!sts_i.in_range) begin
          state_d = ST_FINISH;
        end else if (sts_i.pos_eq) begin
          cmd_o.del = 1'b1;
          state_d   = ST_FINISH;
        end else begin
          cmd_o.inc = 1'b1;
        end
      end
      ST_STRIP_SCAN: begin
        // hold the index after a removal: the next keyframe moved into it
        priority if (!sts_i.in_range) begin
          state_d = ST_FINISH;
        end else if (sts_i.pres_zero) begin
          cmd_o.del = 1'b1;
        end else begin
          cmd_o.inc = 1'b1;
        end
      end
      ST_Q_RD: begin
        if (sts_i.in_range) begin
          cmd_o.q_rd = 1'b1;
          state_d    = ST_Q_UPD;
        end else begin
          state_d = sts_i.interp ? ST_Q_MUL : ST_FINISH;
        end
      end
      ST_Q_UPD: begin
        cmd_o.q_upd = 1'b1;
        cmd_o.inc   = 1'b1;
        state_d     = ST_Q_RD;
      end
      ST_Q_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_Q_DIVI;
      end
      ST_Q_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_Q_DIV;
      end
      ST_Q_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_DISPATCH)) else $error("load without dispatch");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q) else $error("result not presented");
`endif

endmodule

>>> sv/keyframe_table_interpolator.sv
// Keyframe table interpolator: top level joining sequencer and datapath.
//
// Slave stream: one request per transaction. tuser carries the request type
// and the timestamp flag, tdata the key point, property, value and query point.
// Master stream: one result per request (value, found flag, status).
// The user must write the duration register through cfg_we_i/cfg_wdata_i
// only while idle; the block itself does not enforce it. A set scans to the
// key's position, then writes the value, first creating the keyframe if it is
// new (a full table sets status instead); a remove scans to the key; a strip
// walks every stored keyframe; a query reads and updates on each stored
// keyframe, then, when it interpolates, runs one multiply, one divider setup
// and a 60-step restoring divider at one quotient bit per cycle.
// Reset empties the table and sets duration to 256; no clearing pass is run.
// The result register holds while the receiver stalls; the next request is
// taken meanwhile and waits in its last step until the result is taken.
module keyframe_table_interpolator #(
  parameter int MAX_KEYFRAMES  = kti_pkg::MAX_KEYFRAMES_DEF,
  parameter int NUM_PROPERTIES = kti_pkg::NUM_PROPERTIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // duration
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // key_point[16:0], property_index[22:17], new_value[46:23], query_point[63:47]
  input  logic [63:0] s_axis_tdata_i,
  // req_type[1:0], at_is_timestamp[2]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_value[23:0]
  output logic [23:0] m_axis_tdata_o,
  // found[0], status[1]
  output logic [1:0]  m_axis_tuser_o
);
  import kti_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kti_datapath #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES),
    .NUM_PROPERTIES(NUM_PROPERTIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (s_axis_tuser_i[1:0]),
    .key_point_i      (s_axis_tdata_i[16:0]),
    .property_index_i (s_axis_tdata_i[22:17]),
    .new_value_i      (s_axis_tdata_i[46:23]),
    .query_point_i    (s_axis_tdata_i[63:47]),
    .at_is_timestamp_i(s_axis_tuser_i[2]),
    .result_value_o   (m_axis_tdata_o),
    .found_o          (m_axis_tuser_o[0]),
    .status_o         (m_axis_tuser_o[1])
  );

endmodule

>>> tb/sv/keyframe_table_interpolator_tb.sv
// Self-checking testbench for the keyframe table interpolator stream block.
module keyframe_table_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kti_pkg::*;

  localparam int NKEY  = MAX_KEYFRAMES_DEF;
  localparam int NPROP = NUM_PROPERTIES_DEF;
  localparam int LIMIT = 3_000_000;

  typedef struct packed {
    logic [23:0] value;
    logic        has;
    logic        status;
  } answer_t;

  class keyframe_scoreboard;
    logic [15:0]        duration;
    int                 count;
    logic [16:0]        pos [NKEY];
    logic signed [23:0] vals [NKEY][NPROP];
    logic [63:0]        pres [NKEY];
    answer_t            answers [$];
    int                 errors;

    function void clear();
      duration = DURATION_RESET;
      count    = 0;
      errors   = 0;
      for (int i = 0; i < NKEY; i++) pres[i] = '0;
    endfunction

    function void drop_slot(int i);
      for (int j = i; j < count - 1; j++) begin
        pos[j]  = pos[j+1];
        vals[j] = vals[j+1];
        pres[j] = pres[j+1];
      end
      count--;
    endfunction

    // round half up of p / d, d > 0
    function longint round_div(longint p, longint d);
      longint m;
      if (p >= 0) return (2 * p + d) / (2 * d);
      m = -p;
      if (2 * m <= d) return 0;
      return -((2 * m - d + 2 * d - 1) / (2 * d));
    endfunction

    function logic set_value(logic [16:0] key, logic [5:0] prop, logic signed [23:0] val);
      int i;
      i = 0;
      while (i < count && pos[i] < key) i++;
      if (!(i < count && pos[i] == key)) begin
        if (count >= NKEY) return 1'b1;
        for (int j = count; j > i; j--) begin
          pos[j]  = pos[j-1];
          vals[j] = vals[j-1];
          pres[j] = pres[j-1];
        end
        count++;
        pos[i]  = key;
        pres[i] = '0;
      end
      vals[i][prop] = val;
      pres[i][prop] = 1'b1;
      return 1'b0;
    endfunction

    function answer_t interpolate(logic [5:0] prop, logic [16:0] qp, logic ts);
      answer_t a;
      logic hp, hn;
      longint tp, tn, at, t, vp, vn, r;
      a = '0; hp = 0; hn = 0; tp = 0; tn = 0; vp = 0; vn = 0;
      at = ts ? (longint'(qp) << 16) : longint'(qp);
      for (int i = 0; i < count; i++) begin
        if (pres[i][prop]) begin
          t = ts ? longint'(pos[i]) * longint'(duration) : longint'(pos[i]);
          if (t <= at && (!hp || tp < t)) begin hp = 1; tp = t; vp = vals[i][prop]; end
          if (t >= at && (!hn || tn > t)) begin hn = 1; tn = t; vn = vals[i][prop]; end
        end
      end
      if (hp && hn) r = (tp == tn) ? vp : vp + round_div((vn - vp) * (at - tp), tn - tp);
      else if (hp) r = vp;
      else r = vn;
      a.has = hp || hn;
      a.value = a.has ? r[23:0] : '0;
      return a;
    endfunction

    function void note_request(req_e req, logic [16:0] key, logic [5:0] prop,
                               logic signed [23:0] val, logic [16:0] qp, logic ts);
      answer_t a;
      int i;
      a = '0;
      case (req)
        REQ_SET: a.status = set_value(key, prop, val);
        REQ_REMOVE: begin
          for (i = 0; i < count; i++) if (pos[i] == key) break;
          if (i < count) drop_slot(i);
        end
        REQ_QUERY: a = interpolate(prop, qp, ts);
        default: begin
          i = 0;
          while (i < count) if (pres[i] == '0) drop_slot(i); else i++;
        end
      endcase
      answers.push_back(a);
    endfunction

    function void check_result(logic [23:0] value, logic [1:0] flags);
      answer_t e;
      if (answers.size() == 0) begin
        $error("unexpected result value %h flags %b", value, flags);
        errors++;
        return;
      end
      e = answers.pop_front();
      if (value !== e.value) begin
        $error("result_value expected %h actual %h", e.value, value); errors++;
      end
      if (flags[0] !== e.has) begin
        $error("found expected %b actual %b", e.has, flags[0]); errors++;
      end
      if (flags[1] !== e.status) begin
        $error("status expected %b actual %b", e.status, flags[1]); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  keyframe_table_interpolator dut (.*);

  // sample the handshakes as they stand at the rising edge
  clocking mon_cb @(posedge clk_i);
    input rst_ni, s_axis_tready_o, m_axis_tvalid_o, m_axis_tready_i, m_axis_tdata_o,
          m_axis_tuser_o;
  endclocking

  keyframe_scoreboard sb = new();
  bit  idle_on = 1;
  bit  hold_rx = 0;
  int  cycles = 0;
  logic [16:0] key_pool [40];

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[keyframe_table_interpolator] ERROR");
      $finish;
    end
  end

  always @(mon_cb)
    if (mon_cb.rst_ni && mon_cb.m_axis_tvalid_o && mon_cb.m_axis_tready_i)
      sb.check_result(mon_cb.m_axis_tdata_o, mon_cb.m_axis_tuser_o);

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready_i = 0;
        repeat (400) @(negedge clk_i);
        hold_rx = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i = 0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1;
      end
    end
  end

  // offer one request and hold it until it is accepted
  task automatic send(req_e req, logic [16:0] key, logic [5:0] prop,
                      logic [23:0] val, logic [16:0] qp, logic ts);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i = 0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tdata_i  = {qp, val, prop, key};
    s_axis_tuser_i  = {ts, req};
    s_axis_tvalid_i = 1;
    do @(mon_cb); while (!mon_cb.s_axis_tready_o);
    sb.note_request(req, key, prop, val, qp, ts);
    @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 0;
    while (sb.answers.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_duration(logic [15:0] d);
    drain();
    cfg_wdata_i = d;
    cfg_we_i    = 1;
    @(negedge clk_i);
    cfg_we_i    = 0;
    sb.duration = d;
  endtask

  task automatic random_phase(int n);
    int   r;
    logic [16:0] key, qp;
    logic [5:0]  prop;
    logic ts;
    for (int i = 0; i < 40; i++) key_pool[i] = $urandom_range(0, 65536);
    key_pool[0] = 0;
    key_pool[1] = 17'd65536;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0 && $urandom_range(0, 3) == 0) idle_on = 0;
      else if (i % 64 == 0) idle_on = 1;
      r    = $urandom_range(0, 99);
      key  = ($urandom_range(0, 19) == 0) ? 17'($urandom) : key_pool[$urandom_range(0, 39)];
      prop = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
      ts   = $urandom_range(0, 1);
      if (ts) qp = $urandom_range(0, 16) == 0 ? 17'($urandom)
                                            : 17'($urandom_range(0, int'(sb.duration) + 1));
      else    qp = $urandom_range(0, 16) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
      if (r < 45)      send(REQ_SET, key, prop, 24'($urandom), qp, ts);
      else if (r < 82) send(REQ_QUERY, key, prop, 24'($urandom), qp, ts);
      else if (r < 97) send(REQ_REMOVE, key, prop, 24'($urandom), qp, ts);
      else             send(REQ_STRIP, key, prop, 24'($urandom), qp, ts);
    end
  endtask

  initial begin
    sb.clear();
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: extremes, single side, no keyframe, interpolation, timestamp mode, remove and strip
    send(REQ_QUERY,  0, 0, 0, 0, 0);
    send(REQ_SET,    0, 0, 24'h7FFFFF, 0, 0);
    send(REQ_SET,    17'd65536, 0, 24'h800000, 0, 0);
    send(REQ_QUERY,  0, 0, 0, 17'd32768, 0);
    send(REQ_QUERY,  0, 0, 0, 17'd1, 0);
    send(REQ_QUERY,  0, 0, 0, 17'd65536, 0);
    send(REQ_QUERY,  0, 0, 0, 17'h1FFFF, 0);
    send(REQ_SET,    17'd100, 6'd63, 24'h000123, 0, 0);
    send(REQ_QUERY,  0, 6'd63, 0, 17'd50, 0);
    send(REQ_QUERY,  0, 6'd63, 0, 17'd200, 0);
    send(REQ_QUERY,  0, 6'd62, 0, 17'd200, 0);
    send(REQ_SET,    17'h1FFFF, 6'd63, 24'hFFFFFF, 0, 0);
    send(REQ_QUERY,  0, 6'd63, 0, 17'h10000, 0);
    send(REQ_QUERY,  0, 0, 0, 17'd128, 1);
    send(REQ_QUERY,  0, 6'd63, 0, 17'd300, 1);
    send(REQ_REMOVE, 17'd555, 0, 0, 0, 0);
    send(REQ_REMOVE, 17'd100, 0, 0, 0, 0);
    send(REQ_STRIP,  0, 0, 0, 0, 0);
    send(REQ_QUERY,  0, 6'd63, 0, 17'd100, 0);
    send(REQ_SET,    17'd1000, 6'd21, 24'h010000, 0, 0);
    send(REQ_SET,    17'd3000, 6'd21, 24'hFF0000, 0, 0);
    send(REQ_QUERY,  0, 6'd21, 0, 17'd2000, 0);
    send(REQ_QUERY,  0, 6'd21, 0, 17'd1500, 0);

    // sender keeps offering while the receiver holds off: fill and stall
    hold_rx = 1;
    random_phase(280);
    drain();

    write_duration(16'd1);
    random_phase(280);
    write_duration(16'hFFFF);
    random_phase(280);
    write_duration(16'd0);
    random_phase(200);
    write_duration(16'($urandom_range(1, 65535)));
    random_phase(200);
    write_duration(DURATION_RESET);
    random_phase(200);
    idle_on = 0;
    // the last stretch runs at full rate on both sides
    begin
      int r;
      for (int i = 0; i < 10; i++) begin
        r = $urandom_range(0, 1);
        send(r ? REQ_QUERY : REQ_SET, key_pool[$urandom_range(0, 39)], 6'($urandom_range(0, 5)),
             24'($urandom), 17'($urandom_range(0, 65536)), 1'b0);
      end
    end
    idle_on = 0;
    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.answers.size() == 0)
      $display("[keyframe_table_interpolator] OK");
    else
      $display("[keyframe_table_interpolator] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
sv/kti_pkg.sv
sv/kti_ram.sv
sv/kti_datapath.sv
sv/kti_ctrl.sv
sv/keyframe_table_interpolator.sv
tb/sv/keyframe_table_interpolator_tb.sv
